FILE: rtl/core/mpsd_pkg.sv
`timescale 1ns / 1ps

package mpsd_pkg;

    // defaults for the top level parameters
    localparam int CHANNELS_DEF   = 16;
    localparam int FULL_LEVEL_DEF = 100;

    // fixed field widths of the request and result
    localparam int CHAN_IN_W = 4;
    localparam int DUTY_IN_W = 8;
    localparam int IN_DATA_W = 16;
    localparam int MASK_W    = 16;

    typedef enum logic
    {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    // per-cycle control shared by all channel lanes
    typedef struct packed
    {
        logic tick;
        logic wrap;
    } chan_ctl_t;

endpackage

FILE: rtl/core/multichannel_pwm_shadow_duty.sv
`timescale 1ns / 1ps

// multichannel pwm with shadow duty levels
// slave channel: s_tuser selects the request kind (0 = time tick, 1 = duty write),
// s_tdata carries the channel index and the duty level for a write.
// a write stores min(duty, FULL_LEVEL) in the channel's shadow level and gives no result.
// a tick advances the phase 0..FULL_LEVEL; at the wrap to 0 all shadow levels
// move to the active levels, then each tick clears a channel whose level equals
// the phase (full level never clears) and sends the on/off mask on the master side.
// a tick request passes the input register, then the result register, to m_tvalid.
// throughput: one request per cycle while the receiver takes results; set by the single pass through the
// per-channel comparators between the two registers.
// reset clears phase, all levels and the channel on bits, not the result mask; no result is pending after reset.
// when the receiver stalls, the result register holds the mask; a write still
// passes, and a tick waits in the input register until the result is taken.
module multichannel_pwm_shadow_duty #(
    parameter int CHANNELS   = mpsd_pkg::CHANNELS_DEF,
    parameter int FULL_LEVEL = mpsd_pkg::FULL_LEVEL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mpsd_pkg::IN_DATA_W-1:0] s_tdata,   // channel[3:0], duty[11:4], zero pad
    input  logic [0:0]                     s_tuser,   // action[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mpsd_pkg::MASK_W-1:0]    m_tdata    // mask[15:0]
);

    localparam int LEVEL_W = $clog2(FULL_LEVEL + 1);
    localparam int CW      = mpsd_pkg::CHAN_IN_W;
    localparam int DW      = mpsd_pkg::DUTY_IN_W;

    // input register
    logic                    s1_valid_reg;
    mpsd_pkg::action_t       s1_action_reg;
    logic [CW-1:0]           s1_channel_reg;
    logic [DW-1:0]           s1_duty_reg;

    logic [LEVEL_W-1:0]      phase_reg;
    logic [LEVEL_W-1:0]      phase_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [mpsd_pkg::MASK_W-1:0] m_tdata_reg;

    logic                    out_free;
    logic                    s1_fire;
    logic                    tick_fire;
    logic                    write_fire;
    logic                    wrap;
    logic [LEVEL_W-1:0]      duty_sat;
    mpsd_pkg::chan_ctl_t     ctl;
    logic [CHANNELS-1:0]     lane_on;
    logic [mpsd_pkg::MASK_W-1:0] mask_next;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s1_fire    = s1_valid_reg && ((s1_action_reg == mpsd_pkg::ACT_WRITE) || out_free);
    assign tick_fire  = s1_fire && (s1_action_reg == mpsd_pkg::ACT_TICK);
    assign write_fire = s1_fire && (s1_action_reg == mpsd_pkg::ACT_WRITE);
    assign s_tready   = !s1_valid_reg || s1_fire;

    assign duty_sat = (s1_duty_reg > DW'(FULL_LEVEL)) ? LEVEL_W'(FULL_LEVEL)
                                                     : s1_duty_reg[LEVEL_W-1:0];

    assign wrap       = (phase_reg >= LEVEL_W'(FULL_LEVEL));
    assign phase_next = wrap ? '0 : phase_reg + LEVEL_W'(1);

    assign ctl.tick = tick_fire;
    assign ctl.wrap = wrap;

    genvar i;
    generate
        for (i = 0; i < CHANNELS; i++)
        begin : g_lane
            mpsd_chan #(
                .FULL_LEVEL (FULL_LEVEL),
                .LEVEL_W    (LEVEL_W)
            ) u_chan (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .wr      (write_fire && (32'(s1_channel_reg) == 32'(i))),
                .duty    (duty_sat),
                .phase   (phase_next),
                .on_next (lane_on[i])
            );
        end
        // result carries the low sixteen channels only
        for (i = 0; i < mpsd_pkg::MASK_W; i++)
        begin : g_mask
            if (i < CHANNELS)
            begin : g_used
                assign mask_next[i] = lane_on[i];
            end
            else
            begin : g_unused
                assign mask_next[i] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (tick_fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (tick_fire)
            begin
                phase_reg <= phase_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_action_reg  <= mpsd_pkg::action_t'(s_tuser[0]);
            s1_channel_reg <= s_tdata[CW-1:0];
            s1_duty_reg    <= s_tdata[CW+DW-1:CW];
        end
        if (tick_fire)
        begin
            m_tdata_reg <= mask_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // phase never runs past the full level
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= LEVEL_W'(FULL_LEVEL))
        else $error("phase above full level");

    // every tick leaves a result in the output register
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> m_tvalid_reg)
        else $error("tick gave no result");

    // a write never creates a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (write_fire && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("write produced a result");

    // a tick is only taken from the input register when the result slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

FILE: rtl/core/mpsd_chan.sv
`timescale 1ns / 1ps

module mpsd_chan #(
    parameter int FULL_LEVEL = mpsd_pkg::FULL_LEVEL_DEF,
    parameter int LEVEL_W    = $clog2(FULL_LEVEL + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mpsd_pkg::chan_ctl_t ctl,
    input  logic                wr,
    input  logic [LEVEL_W-1:0]  duty,
    input  logic [LEVEL_W-1:0]  phase,
    output logic                on_next
);

    logic [LEVEL_W-1:0] shadow_reg;
    logic [LEVEL_W-1:0] shadow_next;
    logic [LEVEL_W-1:0] active_reg;
    logic [LEVEL_W-1:0] active_next;
    logic               on_reg;
    logic               on_set;

    always_comb
    begin
        shadow_next = wr ? duty : shadow_reg;
        active_next = active_reg;
        on_set      = on_reg;
        on_next     = on_reg;
        if (ctl.tick)
        begin
            // at the wrap the shadow level takes effect for the new period
            if (ctl.wrap)
            begin
                active_next = shadow_reg;
                on_set      = (shadow_reg != '0);
            end
            on_next = on_set;
            if ((active_next == phase) && (active_next != LEVEL_W'(FULL_LEVEL)))
            begin
                on_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= '0;
            active_reg <= '0;
            on_reg     <= 1'b0;
        end
        else
        begin
            shadow_reg <= shadow_next;
            active_reg <= active_next;
            on_reg     <= on_next;
        end
    end

endmodule

FILE: test/tb_multichannel_pwm_shadow_duty.sv
`timescale 1ns / 1ps

module tb_multichannel_pwm_shadow_duty;

    localparam int  CLK_PERIOD = 4;
    localparam int  NCH        = mpsd_pkg::CHANNELS_DEF;
    localparam int  FULL       = mpsd_pkg::FULL_LEVEL_DEF;
    localparam int  RAND_ITEMS = 1030;
    localparam int  DIR_ROWS_N = 21;

    typedef struct packed
    {
        mpsd_pkg::action_t act;
        logic [3:0]        chan;
        logic [7:0]        duty;
        logic              typed;
        logic [15:0]       mask;
    } dir_row_t;

    // directed rows; mask is only meaningful where typed is set
    localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
        '{mpsd_pkg::ACT_TICK,  4'd0,  8'd0,   1'b1, 16'h0000},
        '{mpsd_pkg::ACT_TICK,  4'd0,  8'd0,   1'b1, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd0,  8'd0,   1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd15, 8'd255, 1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd1,  8'd100, 1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd2,  8'd101, 1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd3,  8'd1,   1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd4,  8'd99,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd5,  8'h80,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd6,  8'h7f,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd7,  8'h55,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd8,  8'haa,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd10, 8'd4,   1'b0, 16'h0000},
        '{mpsd_pkg::ACT_TICK,  4'd15, 8'hff,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd15, 8'd50,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_TICK,  4'd5,  8'h5a,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd9,  8'h0f,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd12, 8'hf0,  1'b0, 16'h0000},
        '{mpsd_pkg::ACT_TICK,  4'd0,  8'd0,   1'b0, 16'h0000},
        '{mpsd_pkg::ACT_WRITE, 4'd14, 8'd2,   1'b0, 16'h0000},
        '{mpsd_pkg::ACT_TICK,  4'd10, 8'd3,   1'b0, 16'h0000}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mpsd_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [0:0]                     s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mpsd_pkg::MASK_W-1:0]    m_tdata;

    // predictor state
    logic [6:0]           pwm_phase;
    logic [6:0]           shadow_lvl [NCH];
    logic [6:0]           active_lvl [NCH];
    logic [15:0]          on_mask;

    logic [15:0]          pending_masks [$];
    int                   mismatch_cnt = 0;
    int                   req_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    multichannel_pwm_shadow_duty u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [6:0] clamp_level(input logic [7:0] duty);
        return (duty > FULL) ? 7'(FULL) : duty[6:0];
    endfunction

    // one time slot: advance phase, reload at wrap, clear channels that hit their level
    function automatic logic [15:0] pwm_advance();
        if (pwm_phase >= FULL)
            pwm_phase = '0;
        else
            pwm_phase = pwm_phase + 7'd1;
        if (pwm_phase == 0)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                active_lvl[i] = shadow_lvl[i];
                on_mask[i]    = (shadow_lvl[i] != 0);
            end
        end
        for (int i = 0; i < NCH; i++)
        begin
            if (active_lvl[i] == pwm_phase && active_lvl[i] != FULL)
                on_mask[i] = 1'b0;
        end
        return on_mask;
    endfunction

    task automatic predict_request(input mpsd_pkg::action_t act, input logic [3:0] chan,
                                   input logic [7:0] duty, input logic typed,
                                   input logic [15:0] typed_mask);
        logic [15:0] next_mask;
        if (act == mpsd_pkg::ACT_WRITE)
        begin
            if (chan < NCH)
                shadow_lvl[chan] = clamp_level(duty);
        end
        else
        begin
            next_mask = pwm_advance();
            pending_masks.push_back(typed ? typed_mask : next_mask);
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_req(input mpsd_pkg::action_t act, input logic [3:0] chan,
                            input logic [7:0] duty, input logic typed = 1'b0,
                            input logic [15:0] typed_mask = '0);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, duty, chan};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(act, chan, duty, typed, typed_mask);
        req_count++;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 1'($urandom);
            @(negedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_masks.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'(FULL);
            2:       return 8'($urandom_range(FULL + 1, 255));
            3:       return 8'd1;
            4:       return 8'(FULL - 1);
            5:       return 8'(pwm_phase) + 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_burst(input int n);
        for (int i = 0; i < n; i++)
            send_req(mpsd_pkg::ACT_WRITE, 4'($urandom_range(0, 15)), pick_level());
    endtask

    task automatic tick_run(input int n);
        for (int i = 0; i < n; i++)
            send_req(mpsd_pkg::ACT_TICK, 4'($urandom), 8'($urandom));
    endtask

    task automatic random_sequence();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                write_burst($urandom_range(1, 6));
                tick_run($urandom_range(5, 60));
            end
            6, 7:
                tick_run($urandom_range(80, 150));
            8:
            begin
                for (int i = 0; i < $urandom_range(1, 8); i++)
                    send_req(mpsd_pkg::action_t'($urandom_range(0, 1)), 4'($urandom),
                             8'($urandom));
            end
            default:
            begin
                // land writes in the last slot so they are picked up by the reload
                while (pwm_phase != FULL)
                    tick_run(1);
                write_burst($urandom_range(1, 4));
                tick_run($urandom_range(1, 3));
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: unexpected mask, expected none actual %h", $time, m_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_masks.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: mask mismatch, expected %h actual %h", $time, want, m_tdata);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin
        pwm_phase = '0;
        on_mask   = '0;
        for (int i = 0; i < NCH; i++)
        begin
            shadow_lvl[i] = '0;
            active_lvl[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 69;
        for (int r = 0; r < DIR_ROWS_N; r++)
            send_req(DIR_ROWS[r].act, DIR_ROWS[r].chan, DIR_ROWS[r].duty,
                     DIR_ROWS[r].typed, DIR_ROWS[r].mask);

        for (int m = 0; m < 3; m++)
        begin
            // hold off until the result side is empty before each idle pattern
            drain_results();
            send_idle_pct = (m == 0) ? 13 : (m == 1) ? 69 : 0;
            recv_idle_pct = (m == 0) ? 69 : (m == 1) ? 13 : 0;
            while (req_count < DIR_ROWS_N + (m + 1) * RAND_ITEMS / 3)
                random_sequence();
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("tb_multichannel_pwm_shadow_duty: clean");
        else
            $display("tb_multichannel_pwm_shadow_duty: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_multichannel_pwm_shadow_duty: errors");
        $finish;
    end

endmodule
